// ===== design/md5_pkg.sv =====
// md5 package: controller states, command and status structs, round tables
// and helper functions shared by the controller, datapath and top level
// no dependencies
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] POS_LAST      = 6'd63;
    localparam logic [5:0] POS_LEN_START = 6'd56;
    localparam logic [5:0] ROUND_LAST    = 6'd63;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_CMP_PREP,
        ST_CMP_ROUND,
        ST_CMP_FOLD,
        ST_DONE
    } md5_state_t;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } md5_src_t;

    typedef struct packed {
        logic     take;
        logic     wr_en;
        md5_src_t wr_src;
        logic     len_add;
        logic     prep;
        logic     round;
        logic     fold;
        logic     emit;
    } md5_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_len;
        logic round_last;
        logic out_busy;
    } md5_status_t;

    // message word index used by round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] res;
        res = r[3:0];
        case (r[5:4])
            2'd0: res = r[3:0];
            2'd1: res = 4'(r[3:0] * 4'd5 + 4'd1);
            2'd2: res = 4'(r[3:0] * 4'd3 + 4'd5);
            default: res = 4'(r[3:0] * 4'd7);
        endcase
        return res;
    endfunction

    function automatic logic [4:0] shift_amt(input logic [5:0] r);
        logic [4:0] s;
        s = 5'd7;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] round_fn(input logic [1:0] grp, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        f = '0;
        case (grp)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

// ===== design/md5_if.sv =====
// md5 stream interfaces: byte input channel and digest output channel
// valid/ready handshake; no dependencies
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;

    modport source (output valid, output data_byte, output byte_present,
                    output message_end, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input message_end, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;

    modport source (output valid, output digest_word0, output digest_word1,
                    output digest_word2, output digest_word3, input ready);
    modport sink (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, output ready);
endinterface

// ===== design/md5_message_digest.sv =====
// md5 top level: a plain byte is taken while idle; a byte that fills the block
// starts a compression (load, 64 rounds on the single round unit, fold) before the next
// transaction is taken. message end pads the block one byte at a time (mark, zeros,
// length, plus one or two compressions), then the digest is registered.
// asynchronous active-low reset loads the initial chaining value and clears
// the byte and length counters; depends on md5_pkg, md5_if, md5_ctrl, md5_dp
module md5_message_digest (
    input  logic      clk,
    input  logic      rst_n,
    md5_in_if.sink    msg,
    md5_out_if.source digest
);
    import md5_pkg::*;

    md5_cmd_t    cmd;
    md5_status_t status;

    md5_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (msg.valid),
        .byte_present (msg.byte_present),
        .message_end  (msg.message_end),
        .status       (status),
        .cmd          (cmd)
    );

    md5_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (msg.data_byte),
        .out_ready    (digest.ready),
        .status       (status),
        .out_valid    (digest.valid),
        .digest_word0 (digest.digest_word0),
        .digest_word1 (digest.digest_word1),
        .digest_word2 (digest.digest_word2),
        .digest_word3 (digest.digest_word3)
    );

    assign msg.ready = cmd.take;

    // block store must not change while rounds read it
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.wr_en && (cmd.round || cmd.prep)))
        else $error("block write during compression");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.prep |=> cmd.round)
        else $error("round sequence did not follow load");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |=> digest.valid)
        else $error("digest not presented after emit");

    assert property (@(posedge clk) disable iff (!rst_n) msg.ready |-> !(cmd.round || cmd.fold))
        else $error("input taken while compressing");

endmodule

// ===== design/md5_ctrl.sv =====
// md5 controller: sequences byte intake, padding, compression and digest output
// depends on md5_pkg
module md5_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                byte_present,
    input  logic                message_end,
    input  md5_pkg::md5_status_t status,
    output md5_pkg::md5_cmd_t    cmd
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;
    md5_state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        cmd.wr_src = SRC_DATA;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.len_add = 1'b1;
                    end
                    if (byte_present && status.pos_last)
                    begin
                        // block full: compress, then pad if the message ended too
                        ret_next   = message_end ? ST_PAD_MARK : ST_IDLE;
                        state_next = ST_CMP_PREP;
                    end
                    else if (message_end)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_MARK;
                if (status.pos_last)
                begin
                    ret_next   = ST_PAD_ZERO;
                    state_next = ST_CMP_PREP;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (status.pos_len)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = SRC_ZERO;
                    if (status.pos_last)
                    begin
                        ret_next   = ST_PAD_ZERO;
                        state_next = ST_CMP_PREP;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_LEN;
                if (status.pos_last)
                begin
                    ret_next   = ST_DONE;
                    state_next = ST_CMP_PREP;
                end
            end
            ST_CMP_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_CMP_ROUND;
            end
            ST_CMP_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_last)
                begin
                    state_next = ST_CMP_FOLD;
                end
            end
            ST_CMP_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/md5_dp.sv =====
// md5 datapath: block store, length counter, chaining value, round unit and
// digest output register; depends on md5_pkg
module md5_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  md5_pkg::md5_cmd_t    cmd,
    input  logic [7:0]           data_byte,
    input  logic                 out_ready,
    output md5_pkg::md5_status_t status,
    output logic                 out_valid,
    output logic [31:0]          digest_word0,
    output logic [31:0]          digest_word1,
    output logic [31:0]          digest_word2,
    output logic [31:0]          digest_word3
);
    import md5_pkg::*;

    logic [31:0] blk_reg [16];
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  round_reg, round_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] sum_reg;
    logic [31:0] dig_reg [4];

    logic [7:0]  wr_byte;
    logic [5:0]  round_succ;
    logic [31:0] f_val;
    logic [31:0] b_new;
    logic [31:0] sum_round;
    logic [31:0] sum_prep;

    always_comb
    begin
        case (cmd.wr_src)
            SRC_DATA: wr_byte = data_byte;
            SRC_MARK: wr_byte = PAD_MARK_BYTE;
            SRC_ZERO: wr_byte = 8'h00;
            default:  wr_byte = len_reg[{pos_reg[2:0], 3'b000} +: 8];
        endcase
    end

    assign round_succ = round_reg + 6'd1;
    assign f_val      = round_fn(round_reg[5:4], b_reg, c_reg, d_reg);
    assign b_new      = b_reg + rotl(sum_reg + f_val, shift_amt(round_reg));
    // next round's a is today's d, so its operand sum is computed ahead and held in sum_reg
    assign sum_round  = d_reg + ROUND_K[round_succ] + blk_reg[msg_index(round_succ)];
    assign sum_prep   = chain_reg[0] + ROUND_K[0] + blk_reg[0];

    always_comb
    begin
        pos_next       = pos_reg;
        len_next       = len_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg;
        chain_next     = chain_reg;
        if (cmd.wr_en)
        begin
            pos_next = pos_reg + 6'd1;
        end
        if (cmd.len_add)
        begin
            len_next = len_reg + 64'd8;
        end
        if (cmd.prep)
        begin
            round_next = '0;
        end
        else if (cmd.round)
        begin
            round_next = round_succ;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.fold)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            pos_next       = '0;
            len_next       = '0;
            chain_next[0]  = IV_A;
            chain_next[1]  = IV_B;
            chain_next[2]  = IV_C;
            chain_next[3]  = IV_D;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            chain_reg[0]  <= IV_A;
            chain_reg[1]  <= IV_B;
            chain_reg[2]  <= IV_C;
            chain_reg[3]  <= IV_D;
        end
        else
        begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            blk_reg[pos_reg[5:2]][{pos_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
        if (cmd.prep)
        begin
            a_reg   <= chain_reg[0];
            b_reg   <= chain_reg[1];
            c_reg   <= chain_reg[2];
            d_reg   <= chain_reg[3];
            sum_reg <= sum_prep;
        end
        else if (cmd.round)
        begin
            a_reg   <= d_reg;
            b_reg   <= b_new;
            c_reg   <= b_reg;
            d_reg   <= c_reg;
            sum_reg <= sum_round;
        end
        if (cmd.emit)
        begin
            dig_reg <= chain_reg;
        end
    end

    assign status.pos_last   = (pos_reg == POS_LAST);
    assign status.pos_len    = (pos_reg == POS_LEN_START);
    assign status.round_last = (round_reg == ROUND_LAST);
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign digest_word0 = dig_reg[0];
    assign digest_word1 = dig_reg[1];
    assign digest_word2 = dig_reg[2];
    assign digest_word3 = dig_reg[3];

endmodule

// ===== tb/md5_message_digest_tb.sv =====
// md5_message_digest_tb: drives byte-stream messages into md5_message_digest,
// recomputes every digest with a behavioral md5 and compares each output word
// depends on md5_if (md5_in_if, md5_out_if) and the md5_message_digest rtl
module md5_message_digest_tb;

    localparam int STALL_LIMIT   = 20000;
    localparam int ITEM_TARGET   = 450;
    localparam int DIGEST_TARGET = 12;
    localparam int TAIL_CYCLES   = 300;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_FIRST = 8'h80;
    localparam logic [5:0]  LEN_SLOT  = 6'd56;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_AMOUNT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [31:0] word3;
    } digest_t;

    logic clk;
    logic rst_n;

    md5_in_if  msg_if ();
    md5_out_if dig_if ();

    md5_message_digest u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (dig_if)
    );

    // behavioral md5 state
    logic [31:0] hash_state [4];
    logic [31:0] msg_block [16];
    logic [5:0]  block_pos;
    logic [63:0] msg_bits;

    digest_t expected_digests [$];
    digest_t want;

    int fail_count;
    int item_count;
    int message_count;
    int checked_count;
    int tx_idle_pct;
    int rx_idle_pct;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic hash_reset();
        hash_state[0] = INIT_A;
        hash_state[1] = INIT_B;
        hash_state[2] = INIT_C;
        hash_state[3] = INIT_D;
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
        block_pos = '0;
        msg_bits  = '0;
    endtask

    task automatic hash_compress();
        logic [31:0] a, b, c, d, f, t, sum;
        int g;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (int r = 0; r < 64; r++)
        begin
            case (r / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            sum = a + f + SINE_K[r] + msg_block[g];
            t = d;
            d = c;
            c = b;
            b = b + rol32(sum, ROT_AMOUNT[(r / 16) * 4 + (r % 4)]);
            a = t;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
    endtask

    task automatic hash_absorb(input logic [7:0] v);
        msg_block[block_pos[5:2]][8 * block_pos[1:0] +: 8] = v;
        block_pos = block_pos + 6'd1;
        if (block_pos == 6'd0)
            hash_compress();
    endtask

    // apply one accepted transaction; a message end queues its digest
    task automatic hash_item(input logic [7:0] b, input logic present, input logic last);
        logic [63:0] len;
        digest_t d;
        if (present)
        begin
            msg_bits = msg_bits + 64'd8;
            hash_absorb(b);
        end
        if (last)
        begin
            len = msg_bits;
            hash_absorb(PAD_FIRST);
            while (block_pos != LEN_SLOT)
                hash_absorb(8'h00);
            for (int k = 0; k < 8; k++)
                hash_absorb(len[8 * k +: 8]);
            d.word0 = hash_state[0];
            d.word1 = hash_state[1];
            d.word2 = hash_state[2];
            d.word3 = hash_state[3];
            expected_digests.push_back(d);
            message_count++;
            hash_reset();
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back transactions keep valid up
    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            msg_if.valid = 1'b0;
            @(negedge clk);
        end
        msg_if.valid        = 1'b1;
        msg_if.data_byte    = b;
        msg_if.byte_present = present;
        msg_if.message_end  = last;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        hash_item(b, present, last);
        if (present || last)
            item_count++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        msg_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (expected_digests.size() != 0)
            @(negedge clk);
    endtask

    // len bytes, optional ignored transactions in between, last byte may carry the end
    task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
        int body;
        body = (end_on_byte && len > 0) ? len - 1 : len;
        for (int i = 0; i < body; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        end
        if (end_on_byte && len > 0)
            send_item(8'($urandom_range(255)), 1'b1, 1'b1);
        else
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    function automatic int pick_length();
        int sel;
        int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        sel = $urandom_range(99);
        if (sel < 50)
            return $urandom_range(8);
        else if (sel < 75)
            return $urandom_range(60, 9);
        else if (sel < 92)
            return edges[$urandom_range(9)];
        else
            return $urandom_range(200, 61);
    endfunction

    task automatic test_empty_message();
        send_item(8'hff, 1'b0, 1'b1);
        // a second empty message right after shows the state was cleared
        send_item(8'h00, 1'b0, 1'b1);
        stop_sending();
    endtask

    task automatic test_byte_with_end();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        stop_sending();
    endtask

    task automatic test_separate_end();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        stop_sending();
    endtask

    task automatic test_ignored_bytes();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'haa, 1'b0, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        stop_sending();
    endtask

    task automatic test_random_messages(input int item_goal, input int digest_goal);
        int items_start;
        int msgs_start;
        items_start = item_count;
        msgs_start  = message_count;
        while (item_count - items_start < item_goal || message_count - msgs_start < digest_goal)
        begin
            send_message(pick_length(), bit'($urandom_range(1)),
                         ($urandom_range(3) == 0) ? 15 : 0);
            // sender holds off now and then until the block has caught up
            if ($urandom_range(9) == 0)
                wait_drained();
        end
        stop_sending();
    endtask

    // checks each digest transaction against the oldest queued expectation
    always @(posedge clk)
    begin
        if (rst_n && dig_if.valid && dig_if.ready)
        begin
            if (expected_digests.size() == 0)
            begin
                $error("digest transaction with none expected: %08h %08h %08h %08h",
                       dig_if.digest_word0, dig_if.digest_word1,
                       dig_if.digest_word2, dig_if.digest_word3);
                fail_count++;
            end
            else
            begin
                want = expected_digests.pop_front();
                checked_count++;
                if (dig_if.digest_word0 !== want.word0)
                begin
                    $error("digest_word0 expected %08h actual %08h",
                           want.word0, dig_if.digest_word0);
                    fail_count++;
                end
                if (dig_if.digest_word1 !== want.word1)
                begin
                    $error("digest_word1 expected %08h actual %08h",
                           want.word1, dig_if.digest_word1);
                    fail_count++;
                end
                if (dig_if.digest_word2 !== want.word2)
                begin
                    $error("digest_word2 expected %08h actual %08h",
                           want.word2, dig_if.digest_word2);
                    fail_count++;
                end
                if (dig_if.digest_word3 !== want.word3)
                begin
                    $error("digest_word3 expected %08h actual %08h",
                           want.word3, dig_if.digest_word3);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        dig_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog: ends the run after too many cycles without any transaction
    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready))
                stall = 0;
            else
                stall++;
        end
        $error("no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        msg_if.valid        = 1'b0;
        msg_if.data_byte    = '0;
        msg_if.byte_present = 1'b0;
        msg_if.message_end  = 1'b0;
        dig_if.ready        = 1'b0;
        fail_count    = 0;
        item_count    = 0;
        message_count = 0;
        checked_count = 0;
        tx_idle_pct   = 31;
        rx_idle_pct   = 56;
        hash_reset();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_message();
        test_byte_with_end();
        test_separate_end();
        test_ignored_bytes();
        wait_drained();

        test_random_messages(ITEM_TARGET / 3, DIGEST_TARGET / 3);
        wait_drained();

        tx_idle_pct = 56;
        rx_idle_pct = 31;
        test_random_messages(ITEM_TARGET / 3, DIGEST_TARGET / 3);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_messages(ITEM_TARGET / 3, DIGEST_TARGET / 3);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d byte/end transactions over %0d messages, %0d digests compared",
                 item_count, message_count, checked_count);
        $display("empty, single-byte, block-boundary and multi-block messages under three stall mixes");
        if (fail_count == 0 && expected_digests.size() == 0)
            $display("PASS");
        else
        begin
            if (expected_digests.size() != 0)
                $error("%0d expected digests never arrived", expected_digests.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
